@@ src/gfa_pkg.sv @@
package gfa_pkg;

  localparam int unsigned MaxDegree = 64;
  localparam int unsigned DegW      = $clog2(MaxDegree + 2);
  localparam int unsigned ElemW     = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_INV = 2'd2,
    OP_RSV = 2'd3
  } opcode_e;

  typedef struct packed {
    logic done;
    logic fail;
  } inv_status_t;

  function automatic logic [DegW-1:0] clamp_degree(logic [DegW-1:0] d);
    logic [DegW-1:0] m;
    m = d;
    if (d < DegW'(2)) begin
      m = DegW'(2);
    end else if (d > DegW'(MaxDegree)) begin
      m = DegW'(MaxDegree);
    end
    return m;
  endfunction

  function automatic logic [ElemW-1:0] low_mask(logic [DegW-1:0] m);
    logic [ElemW-1:0] mask;
    if (m >= DegW'(ElemW)) begin
      mask = '1;
    end else begin
      mask = (ElemW'(1) << m) - ElemW'(1);
    end
    return mask;
  endfunction

endpackage

@@ src/gfa_euclid.sv @@
module gfa_euclid import gfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ElemW-1:0] operand_i,
  input  logic [DegW-1:0]  degree_i,
  output inv_status_t      status_o,
  output logic [ElemW-1:0] inverse_o
);

  typedef enum logic [1:0] {
    E_IDLE = 2'b01,
    E_RUN  = 2'b10
  } euclid_state_e;

  euclid_state_e    state_q, state_d;
  logic [ElemW:0]   u_q, u_d;
  logic [ElemW-1:0] v_q, v_d;
  logic [ElemW-1:0] z_q, z_d;
  logic [ElemW-1:0] g_q, g_d;
  logic [DegW-1:0]  lu_q, lu_d;
  logic [DegW-1:0]  lv_q, lv_d;
  logic [DegW-1:0]  m_q, m_d;
  logic             done_q, done_d;
  logic             fail_q, fail_d;
  logic [ElemW-1:0] inv_q, inv_d;

  logic [ElemW-1:0] a_masked;
  logic [DegW-1:0]  lu_idx;
  logic [5:0]       lv_idx;
  logic             u_top;
  logic             v_top;
  logic [DegW-1:0]  sh;

  assign a_masked = operand_i & low_mask(degree_i);
  assign lu_idx   = lu_q - DegW'(1);
  assign lv_idx   = 6'(lv_q - DegW'(1));
  assign u_top    = (lu_q != '0) && u_q[lu_idx];
  assign v_top    = v_q[lv_idx];
  assign sh       = lu_q - lv_q;

  always_comb begin
    state_d = state_q;
    u_d     = u_q;
    v_d     = v_q;
    z_d     = z_q;
    g_d     = g_q;
    lu_d    = lu_q;
    lv_d    = lv_q;
    m_d     = m_q;
    done_d  = 1'b0;
    fail_d  = fail_q;
    inv_d   = inv_q;
    unique case (state_q)
      E_IDLE: begin
        if (start_i) begin
          if (a_masked == '0) begin
            done_d = 1'b1;
            fail_d = 1'b1;
            inv_d  = '0;
          end else if (a_masked == ElemW'(1)) begin
            done_d = 1'b1;
            fail_d = 1'b0;
            inv_d  = ElemW'(1);
          end else begin
            u_d     = ((ElemW+1)'(1) << degree_i) | (ElemW+1)'(3);
            lu_d    = degree_i + DegW'(1);
            v_d     = a_masked;
            lv_d    = degree_i;
            z_d     = '0;
            g_d     = ElemW'(1);
            m_d     = degree_i;
            state_d = E_RUN;
          end
        end
      end
      E_RUN: begin
        priority if ((lu_q != '0) && !u_top) begin
          lu_d = lu_q - DegW'(1);
        end else if (!v_top) begin
          lv_d = lv_q - DegW'(1);
        end else if (lu_q <= DegW'(1)) begin
          done_d  = 1'b1;
          fail_d  = (lu_q == '0);
          inv_d   = (lu_q == '0) ? '0 : (z_q & low_mask(m_q));
          state_d = E_IDLE;
        end else if (lu_q < lv_q) begin
          u_d  = {1'b0, v_q};
          v_d  = u_q[ElemW-1:0];
          z_d  = g_q;
          g_d  = z_q;
          lu_d = lv_q;
          lv_d = lu_q;
        end else begin
          u_d = u_q ^ ({1'b0, v_q} << sh);
          z_d = z_q ^ (g_q << sh);
        end
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      done_q  <= 1'b0;
      fail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      fail_q  <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    v_q   <= v_d;
    z_q   <= z_d;
    g_q   <= g_d;
    lu_q  <= lu_d;
    lv_q  <= lv_d;
    m_q   <= m_d;
    inv_q <= inv_d;
  end

  assign status_o.done = done_q;
  assign status_o.fail = fail_q;
  assign inverse_o     = inv_q;

endmodule

@@ src/gf2m_field_alu.sv @@
// Arithmetic unit over GF(2^m) with field polynomial x^m + x + 1, m taken from
// the degree register written from cfg_wdata_i (clamped to 2..64) when start
// is accepted. A beat is accepted when start is high and busy is low; its
// result appears on result_o and no_inverse_o for exactly one cycle with done_o
// high, and must be taken then, since the unit cannot be held off. Add and the
// unused opcode return in the cycle after acceptance and leave busy low.
// Multiply runs one shift-and-add step per cycle through a single reduce-by-x
// unit and returns after its last step. Invert runs a binary extended Euclid
// sequencer that spends each cycle on one degree-tracking bit, one swap, one
// shifted XOR step through two barrel shifters sharing one shift amount, or the
// final check; its run length depends on the operand, and for operands 0 and 1
// it answers without a run. busy stays high while multiply or invert runs.
module gf2m_field_alu import gfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [DegW-1:0]  cfg_wdata_i,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       opcode_i,
  input  logic [ElemW-1:0] operand_a_i,
  input  logic [ElemW-1:0] operand_b_i,
  output logic             done_o,
  output logic [ElemW-1:0] result_o,
  output logic             no_inverse_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_INV  = 3'b100
  } alu_state_e;

  alu_state_e       state_q, state_d;
  logic [DegW-1:0]  degree_q;
  logic [DegW-1:0]  m_q, m_d;
  logic [DegW-1:0]  cnt_q, cnt_d;
  logic [ElemW-1:0] a_q, a_d;
  logic [ElemW-1:0] b_q, b_d;
  logic [ElemW-1:0] acc_q, acc_d;
  logic             done_q, done_d;
  logic [ElemW-1:0] result_q, result_d;
  logic             noinv_q, noinv_d;

  logic             accept;
  opcode_e          op;
  logic [DegW-1:0]  m_eff;
  logic [ElemW-1:0] mask_eff;
  logic [ElemW-1:0] mask_run;
  logic [ElemW-1:0] acc_next;
  logic             inv_start;
  inv_status_t      inv_status;
  logic [ElemW-1:0] inv_result;

  function automatic logic [ElemW-1:0] times_x(logic [ElemW-1:0] v, logic [DegW-1:0] m,
                                               logic [ElemW-1:0] mask);
    logic             top;
    logic [ElemW-1:0] r;
    top = v[6'(m - DegW'(1))];
    r   = (v << 1) & mask;
    if (top) begin
      r = r ^ ElemW'(3);
    end
    return r;
  endfunction

  assign accept    = start && (state_q == S_IDLE);
  assign op        = opcode_e'(opcode_i);
  assign m_eff     = clamp_degree(degree_q);
  assign mask_eff  = low_mask(m_eff);
  assign mask_run  = low_mask(m_q);
  assign acc_next  = b_q[0] ? (acc_q ^ a_q) : acc_q;
  assign inv_start = accept && (op == OP_INV);

  gfa_euclid u_euclid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (inv_start),
    .operand_i (operand_a_i),
    .degree_i  (m_eff),
    .status_o  (inv_status),
    .inverse_o (inv_result)
  );

  always_comb begin
    state_d  = state_q;
    m_d      = m_q;
    cnt_d    = cnt_q;
    a_d      = a_q;
    b_d      = b_q;
    acc_d    = acc_q;
    done_d   = 1'b0;
    result_d = result_q;
    noinv_d  = noinv_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_ADD: begin
              done_d   = 1'b1;
              result_d = (operand_a_i ^ operand_b_i) & mask_eff;
              noinv_d  = 1'b0;
            end
            OP_MUL: begin
              m_d     = m_eff;
              cnt_d   = '0;
              a_d     = operand_a_i & mask_eff;
              b_d     = operand_b_i & mask_eff;
              acc_d   = '0;
              state_d = S_MUL;
            end
            OP_INV: begin
              state_d = S_INV;
            end
            OP_RSV: begin
              done_d   = 1'b1;
              result_d = '0;
              noinv_d  = 1'b0;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_MUL: begin
        acc_d = acc_next;
        a_d   = times_x(a_q, m_q, mask_run);
        b_d   = b_q >> 1;
        cnt_d = cnt_q + DegW'(1);
        if (cnt_q == (m_q - DegW'(1))) begin
          done_d   = 1'b1;
          result_d = acc_next & mask_run;
          noinv_d  = 1'b0;
          state_d  = S_IDLE;
        end
      end
      S_INV: begin
        if (inv_status.done) begin
          done_d   = 1'b1;
          result_d = inv_result;
          noinv_d  = inv_status.fail;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      degree_q <= DegW'(MaxDegree);
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        degree_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q      <= m_d;
    cnt_q    <= cnt_d;
    a_q      <= a_d;
    b_q      <= b_d;
    acc_q    <= acc_d;
    result_q <= result_d;
    noinv_q  <= noinv_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign result_o     = result_q;
  assign no_inverse_o = noinv_q;

endmodule

@@ src/gf2m_field_alu_chk.sv @@
module gf2m_field_alu_chk import gfa_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic [1:0]       opcode_i,
  input logic             done_o,
  input logic [ElemW-1:0] result_o,
  input logic             no_inverse_o
);

  // add and the unused opcode return on the next beat without raising busy
  a_fast_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_ADD || opcode_i == OP_RSV))
      |=> (done_o && !busy))
    else $error("add or unused opcode did not complete in one cycle");

  a_long_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_MUL || opcode_i == OP_INV))
      |=> (busy && !done_o))
    else $error("multiply or invert did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result beat");

  a_noinv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && no_inverse_o) |-> (result_o == '0))
    else $error("no_inverse flagged with nonzero result");

endmodule

bind gf2m_field_alu gf2m_field_alu_chk u_chk (.*);

@@ tb/gf2m_field_alu_tb.sv @@
`timescale 1ns / 100ps

module gf2m_field_alu_tb;
  import gfa_pkg::*;

  localparam int unsigned NumPhases  = 20;
  localparam int unsigned PhaseItems = 70;
  localparam logic [ElemW-1:0] AllOnes = '1;
  localparam logic [ElemW-1:0] TopBit  = {1'b1, {(ElemW-1){1'b0}}};

  typedef struct packed {
    logic [ElemW-1:0] value;
    logic             no_inv;
  } alu_result_t;

  typedef struct packed {
    logic [DegW-1:0]  deg;
    opcode_e          op;
    logic [ElemW-1:0] a;
    logic [ElemW-1:0] b;
    logic             typed;
    logic [ElemW-1:0] res;
    logic             flag;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [DegW-1:0]  cfg_wdata_i;
  logic             start;
  logic             busy;
  logic [1:0]       opcode_i;
  logic [ElemW-1:0] operand_a_i;
  logic [ElemW-1:0] operand_b_i;
  logic             done_o;
  logic [ElemW-1:0] result_o;
  logic             no_inverse_o;

  alu_result_t      pending_results [$];
  logic [DegW-1:0]  model_deg;
  logic             beat_typed;
  logic [ElemW-1:0] beat_value;
  logic             beat_flag;
  int unsigned      mismatches;

  gf2m_field_alu dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .no_inverse_o(no_inverse_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned poly_len(logic [ElemW-1:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < ElemW; i++) begin
      if (v[i]) n = i + 1;
    end
    return n;
  endfunction

  function automatic logic [ElemW-1:0] mul_by_x(logic [ElemW-1:0] v, int unsigned m,
                                               logic [ElemW-1:0] mask);
    logic top;
    top = v[m-1];
    v = (v << 1) & mask;
    if (top) v = v ^ ElemW'(3);
    return v;
  endfunction

  function automatic logic [ElemW-1:0] field_product(logic [ElemW-1:0] a, logic [ElemW-1:0] b,
                                                    int unsigned m, logic [ElemW-1:0] mask);
    logic [ElemW-1:0] acc;
    acc = '0;
    for (int unsigned i = 0; i < m; i++) begin
      if (b[i]) acc = acc ^ a;
      a = mul_by_x(a, m, mask);
    end
    return acc & mask;
  endfunction

  function automatic logic [ElemW-1:0] field_inverse(input logic [ElemW-1:0] a,
                                                    input int unsigned m,
                                                    input logic [ElemW-1:0] mask,
                                                    output logic fail);
    logic [ElemW-1:0] u, v, z, g, t;
    int unsigned      sh, lu, lv;
    fail = 1'b0;
    if (a == '0) begin
      fail = 1'b1;
      return '0;
    end
    if (a == ElemW'(1)) return ElemW'(1);
    sh = m + 1 - poly_len(a);
    u = ElemW'(3) ^ ((a << sh) & mask);
    v = a;
    z = ElemW'(1) << sh;
    g = ElemW'(1);
    while (u > ElemW'(1)) begin
      lu = poly_len(u);
      lv = poly_len(v);
      if (lu < lv) begin
        t = u; u = v; v = t;
        t = z; z = g; g = t;
        sh = lv - lu;
      end else begin
        sh = lu - lv;
      end
      if (sh > 63) begin
        fail = 1'b1;
        return '0;
      end
      u = u ^ (v << sh);
      z = z ^ (g << sh);
    end
    if (u != ElemW'(1)) begin
      fail = 1'b1;
      return '0;
    end
    return z & mask;
  endfunction

  function automatic alu_result_t predict_alu(logic [1:0] op, logic [ElemW-1:0] a_in,
                                              logic [ElemW-1:0] b_in, logic [DegW-1:0] deg);
    alu_result_t      r;
    int unsigned      m;
    logic [ElemW-1:0] mask, a, b;
    logic             fail;
    m = (deg < 2) ? 2 : ((deg > MaxDegree) ? MaxDegree : deg);
    mask = (m >= ElemW) ? AllOnes : ((ElemW'(1) << m) - ElemW'(1));
    a = a_in & mask;
    b = b_in & mask;
    r.value = '0;
    r.no_inv = 1'b0;
    case (op)
      OP_ADD: r.value = a ^ b;
      OP_MUL: r.value = field_product(a, b, m, mask);
      OP_INV: begin
        r.value = field_inverse(a, m, mask, fail);
        r.no_inv = fail;
      end
      default: r.value = '0;
    endcase
    return r;
  endfunction

  function automatic dir_row_t dir_row(logic [DegW-1:0] deg, opcode_e op, logic [ElemW-1:0] a,
                                       logic [ElemW-1:0] b, logic typed,
                                       logic [ElemW-1:0] res, logic flag);
    dir_row_t r;
    r.deg = deg;
    r.op = op;
    r.a = a;
    r.b = b;
    r.typed = typed;
    r.res = res;
    r.flag = flag;
    return r;
  endfunction

  function automatic logic [ElemW-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ElemW'(1);
      2: return AllOnes;
      3: return ElemW'(1) << $urandom_range(0, ElemW - 1);
      4: return ElemW'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [DegW-1:0] phase_degree(int unsigned p);
    case (p)
      0: return DegW'(2);
      1: return DegW'(127);
      2: return DegW'(3);
      3: return DegW'(0);
      4: return DegW'(7);
      5: return DegW'(5);
      6: return DegW'(8);
      7: return DegW'(63);
      8: return DegW'(15);
      9: return DegW'(1);
      10: return DegW'(22);
      11: return DegW'(65);
      12: return DegW'(60);
      13: return DegW'(33);
      14: return DegW'(64);
      15: return DegW'(9);
      default: return DegW'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : check_results
    alu_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          log_mismatch($sformatf("unexpected beat result %h no_inverse %b",
                                 result_o, no_inverse_o));
        end else begin
          want = pending_results.pop_front();
          if (result_o !== want.value || no_inverse_o !== want.no_inv) begin
            log_mismatch($sformatf("result exp %h got %h, no_inverse exp %b got %b",
                                   want.value, result_o, want.no_inv, no_inverse_o));
          end
        end
      end
      if (start && !busy) begin
        if (beat_typed) begin
          want.value = beat_value;
          want.no_inv = beat_flag;
        end else begin
          want = predict_alu(opcode_i, operand_a_i, operand_b_i, model_deg);
        end
        pending_results.push_back(want);
      end
      if (cfg_we_i) model_deg = cfg_wdata_i;
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [ElemW-1:0] a,
                           input logic [ElemW-1:0] b, input int unsigned gap,
                           input logic typed, input logic [ElemW-1:0] res, input logic flag);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    beat_typed = typed;
    beat_value = res;
    beat_flag = flag;
    start <= 1'b1;
    opcode_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_degree(input logic [DegW-1:0] d);
    wait_drained();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    dir_row_t        dir_rows [$];
    dir_row_t        row;
    logic [DegW-1:0] cur_deg;
    logic [1:0]      op;
    int unsigned     pick;
    bit              burst;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = DegW'(64);
    start = 1'b0;
    opcode_i = OP_ADD;
    operand_a_i = '0;
    operand_b_i = '0;
    beat_typed = 1'b0;
    beat_value = '0;
    beat_flag = 1'b0;
    model_deg = DegW'(64);
    mismatches = 0;
    cur_deg = DegW'(64);

    dir_rows.push_back(dir_row(64, OP_ADD, AllOnes, '0, 1, AllOnes, 0));
    dir_rows.push_back(dir_row(64, OP_ADD, AllOnes, AllOnes, 1, '0, 0));
    dir_rows.push_back(dir_row(64, OP_ADD, {16{4'hA}}, {16{4'h5}}, 1, AllOnes, 0));
    dir_rows.push_back(dir_row(64, OP_MUL, '0, AllOnes, 1, '0, 0));
    dir_rows.push_back(dir_row(64, OP_MUL, 64'd1, AllOnes, 1, AllOnes, 0));
    dir_rows.push_back(dir_row(64, OP_MUL, AllOnes, AllOnes, 0, '0, 0));
    dir_rows.push_back(dir_row(64, OP_MUL, TopBit, 64'd2, 1, 64'd3, 0));
    dir_rows.push_back(dir_row(64, OP_INV, '0, AllOnes, 1, '0, 1));
    dir_rows.push_back(dir_row(64, OP_INV, 64'd1, AllOnes, 1, 64'd1, 0));
    dir_rows.push_back(dir_row(64, OP_INV, 64'd2, '0, 0, '0, 0));
    dir_rows.push_back(dir_row(64, OP_INV, AllOnes, '0, 0, '0, 0));
    dir_rows.push_back(dir_row(64, OP_INV, TopBit, AllOnes, 0, '0, 0));
    dir_rows.push_back(dir_row(64, OP_RSV, AllOnes, AllOnes, 1, '0, 0));
    dir_rows.push_back(dir_row(0, OP_ADD, AllOnes, '0, 1, 64'd3, 0));
    dir_rows.push_back(dir_row(0, OP_MUL, 64'd2, 64'd2, 1, 64'd3, 0));
    dir_rows.push_back(dir_row(0, OP_INV, 64'd2, AllOnes, 1, 64'd3, 0));
    dir_rows.push_back(dir_row(0, OP_INV, 64'd4, '0, 1, '0, 1));
    dir_rows.push_back(dir_row(127, OP_ADD, AllOnes, '0, 1, AllOnes, 0));
    dir_rows.push_back(dir_row(127, OP_MUL, TopBit, 64'd2, 1, 64'd3, 0));
    dir_rows.push_back(dir_row(5, OP_INV, 64'd7, '0, 1, '0, 1));
    dir_rows.push_back(dir_row(5, OP_INV, 64'd2, '0, 0, '0, 0));
    dir_rows.push_back(dir_row(5, OP_MUL, 64'd31, 64'd31, 0, '0, 0));
    dir_rows.push_back(dir_row(2, OP_INV, 64'd3, '0, 1, 64'd2, 0));
    dir_rows.push_back(dir_row(1, OP_MUL, 64'd3, 64'd3, 1, 64'd2, 0));
    dir_rows.push_back(dir_row(65, OP_INV, 64'd3, AllOnes, 0, '0, 0));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.deg != cur_deg) begin
        set_degree(row.deg);
        cur_deg = row.deg;
      end
      send_beat(row.op, row.a, row.b, $urandom_range(0, 3), row.typed, row.res, row.flag);
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      set_degree(phase_degree(p));
      burst = (p % 4 == 3);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) == 0) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 5) op = OP_RSV;
        else if (pick < 35) op = OP_ADD;
        else if (pick < 65) op = OP_MUL;
        else op = OP_INV;
        send_beat(op, rand_operand(), rand_operand(), burst ? 0 : $urandom_range(0, 3),
                  0, '0, 0);
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** gf2m_field_alu: PASSED **");
    end else begin
      $display("** gf2m_field_alu: FAILED **");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("** gf2m_field_alu: FAILED **");
    $finish;
  end

endmodule
